// ----- rtl/tftb_pkg.sv -----
package tftb_pkg;

  // Table geometry.
  localparam int unsigned TableDepth = 256;
  localparam int unsigned IdxW       = $clog2(TableDepth);

  // Colour channels: red, green, blue, alpha.
  localparam int unsigned NumChan = 4;
  localparam int unsigned ChanW   = 8;
  localparam int unsigned EntryW  = NumChan * ChanW;

  // Node position: signed fixed point with 16 fraction bits.
  localparam int unsigned PosW  = 18;
  localparam int unsigned FracW = 16;

  // Stream payload widths, the data widths rounded up to whole bytes.
  localparam int unsigned InDataW  = 64;
  localparam int unsigned OutDataW = 40;
  localparam int unsigned ModeW    = 2;

  typedef logic [NumChan-1:0][ChanW-1:0] rgba_t;
  typedef logic [IdxW-1:0]               idx_t;

  typedef enum logic [ModeW-1:0] {
    MODE_CLEAR = 2'd0,
    MODE_NODE  = 2'd1,
    MODE_READ  = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_FILL,
    S_READ
  } state_e;

endpackage

// ----- rtl/tftb_ram.sv -----
module tftb_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/transfer_function_table_builder_core.sv -----
// Channel   Dir  Signals                        Carries
// s_axis    in   tvalid tready tuser tdata      clear, node and read requests
// m_axis    out  tvalid tready tdata            one table entry per read request
//
// Flow: a clear, an ignored request or a node that writes nothing is taken in S_IDLE.
// A read passes through the table read register and then the output register. A node that
// extends the ramp is accepted, then runs the per-channel restoring divide in S_DIV
// (skipped for a zero-length segment) and then writes one table entry per cycle in S_FILL
// (segment length + 1 entries); the single write port of the table memory sets that rate.
// Reset clears all control state and the per-entry valid bits at once; an entry
// that was never written since reset or since a clear reads as zero.
// A read result waits in the output register while m_axis_tready is low; node
// and clear requests are still taken meanwhile, a second read waits behind it.
module transfer_function_table_builder_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Request stream.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // mode[1:0]
  input  logic [tftb_pkg::ModeW-1:0]          s_axis_tuser,
  // node_position[17:0], node_red[25:18], node_green[33:26], node_blue[41:34],
  // node_alpha[49:42], read_index[57:50], zero[63:58]
  input  logic [tftb_pkg::InDataW-1:0]        s_axis_tdata,
  // Result stream.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // entry_red[7:0], entry_green[15:8], entry_blue[23:16], entry_alpha[31:24],
  // table_valid[32], zero[39:33]
  output logic [tftb_pkg::OutDataW-1:0]       m_axis_tdata
);

  import tftb_pkg::*;

  state_e state_q, state_d;

  // Request fields.
  logic                 in_acc;
  logic [PosW-1:0]      in_pos;
  rgba_t                in_color;
  idx_t                 in_index;
  mode_e                in_mode;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign in_mode  = mode_e'(s_axis_tuser);
  assign in_pos   = s_axis_tdata[PosW-1:0];
  assign in_color = rgba_t'(s_axis_tdata[PosW +: EntryW]);
  assign in_index = s_axis_tdata[PosW+EntryW +: IdxW];

  // Position to slot: scale by the last slot number, truncate, clip.
  logic [PosW+IdxW-2:0] pos_prod;
  logic [PosW+IdxW-2-FracW:0] pos_scaled;
  idx_t                 in_slot;

  always_comb begin
    pos_prod   = (PosW+IdxW-1)'(in_pos[PosW-2:0]) * (PosW+IdxW-1)'(TableDepth - 1);
    pos_scaled = pos_prod[PosW+IdxW-2:FracW];
    if (in_pos[PosW-1] || (in_pos == '0)) begin
      in_slot = '0;
    end else if (pos_scaled > (PosW+IdxW-1-FracW)'(TableDepth - 1)) begin
      in_slot = idx_t'(TableDepth - 1);
    end else begin
      in_slot = pos_scaled[IdxW-1:0];
    end
  end

  // Node history.
  idx_t        prev_slot_q;
  rgba_t       prev_color_q;
  logic [1:0]  seen_q;
  logic        seg_go;
  idx_t        seg_len;

  assign seg_go  = (seen_q != 2'd0) && (in_slot >= prev_slot_q);
  assign seg_len = in_slot - prev_slot_q;

  // Segment walk registers.
  idx_t                        fill_idx_q;
  idx_t                        k_q;
  idx_t                        len_q;
  rgba_t                       base_q;
  logic [NumChan-1:0]          neg_q;
  logic [NumChan-1:0][ChanW-1:0] mag_q;
  logic [NumChan-1:0][ChanW-1:0] num_q;
  logic [NumChan-1:0][ChanW-1:0] quo_q;
  logic [NumChan-1:0][ChanW-1:0] rem_q;
  logic [NumChan-1:0][ChanW-1:0] acc_q;
  logic [NumChan-1:0][ChanW-1:0] accr_q;
  logic [$clog2(ChanW)-1:0]    div_cnt_q;
  logic                        div_last;
  logic                        fill_last;

  assign div_last  = (div_cnt_q == ($clog2(ChanW))'(ChanW - 1));
  assign fill_last = (k_q == len_q);

  // Per-lane divider step and accumulator step.
  logic [NumChan-1:0][ChanW:0]   div_trial;
  logic [NumChan-1:0]            div_bit;
  logic [NumChan-1:0][ChanW:0]   accr_sum;
  logic [NumChan-1:0]            accr_wrap;
  rgba_t                         fill_data;

  always_comb begin
    for (int l = 0; l < NumChan; l++) begin
      div_trial[l] = {rem_q[l], num_q[l][ChanW-1]};
      div_bit[l]   = div_trial[l] >= {1'b0, len_q};
      accr_sum[l]  = {1'b0, accr_q[l]} + {1'b0, rem_q[l]};
      accr_wrap[l] = accr_sum[l] >= {1'b0, len_q};
      fill_data[l] = neg_q[l] ? (base_q[l] - acc_q[l]) : (base_q[l] + acc_q[l]);
    end
  end

  // Table memory and its valid bits.
  logic                 ram_we;
  logic                 ram_re;
  logic [EntryW-1:0]    ram_rdata;
  logic [TableDepth-1:0] valid_q;
  logic                 rd_valid_q;

  tftb_ram #(
    .Width (EntryW),
    .Depth (TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (fill_idx_q),
    .wdata_i (EntryW'(fill_data)),
    .re_i    (ram_re),
    .raddr_i (in_index),
    .rdata_o (ram_rdata)
  );

  // Output register.
  logic                 out_valid_q;
  rgba_t                out_entry_q;
  logic                 out_tv_q;
  logic                 tv_hold_q;
  logic                 out_load;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && (in_mode == MODE_NODE) && seg_go) begin
          state_d = (seg_len == '0) ? S_FILL : S_DIV;
        end else if (in_acc && (in_mode == MODE_READ)) begin
          state_d = S_READ;
        end
      end
      S_DIV: begin
        if (div_last) begin
          state_d = S_FILL;
        end
      end
      S_FILL: begin
        if (fill_last) begin
          state_d = S_IDLE;
        end
      end
      S_READ: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    s_axis_tready = (state_q == S_IDLE);
    ram_we        = (state_q == S_FILL);
    ram_re        = in_acc && (in_mode == MODE_READ);
    out_load      = (state_q == S_READ) && (!out_valid_q || m_axis_tready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      seen_q      <= 2'd0;
      prev_slot_q <= '0;
      prev_color_q <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc && (in_mode == MODE_CLEAR)) begin
        seen_q       <= 2'd0;
        prev_slot_q  <= '0;
        prev_color_q <= '0;
        valid_q      <= '0;
      end else if (in_acc && (in_mode == MODE_NODE)) begin
        prev_slot_q  <= in_slot;
        prev_color_q <= in_color;
        if (seen_q != 2'd2) begin
          seen_q <= seen_q + 2'd1;
        end
      end
      if (ram_we) begin
        valid_q[fill_idx_q] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_acc && (in_mode == MODE_NODE)) begin
      fill_idx_q <= prev_slot_q;
      k_q        <= '0;
      len_q      <= seg_len;
      base_q     <= prev_color_q;
      div_cnt_q  <= '0;
      for (int l = 0; l < NumChan; l++) begin
        neg_q[l]  <= in_color[l] < prev_color_q[l];
        mag_q[l]  <= (in_color[l] < prev_color_q[l]) ? (prev_color_q[l] - in_color[l])
                                                     : (in_color[l] - prev_color_q[l]);
        num_q[l]  <= (in_color[l] < prev_color_q[l]) ? (prev_color_q[l] - in_color[l])
                                                     : (in_color[l] - prev_color_q[l]);
        quo_q[l]  <= '0;
        rem_q[l]  <= '0;
        acc_q[l]  <= '0;
        accr_q[l] <= '0;
      end
    end else if (state_q == S_DIV) begin
      div_cnt_q <= div_cnt_q + 1'b1;
      for (int l = 0; l < NumChan; l++) begin
        num_q[l] <= {num_q[l][ChanW-2:0], 1'b0};
        quo_q[l] <= {quo_q[l][ChanW-2:0], div_bit[l]};
        rem_q[l] <= div_bit[l] ? ChanW'(div_trial[l] - {1'b0, len_q})
                               : div_trial[l][ChanW-1:0];
      end
    end else if (state_q == S_FILL) begin
      fill_idx_q <= fill_idx_q + 1'b1;
      k_q        <= k_q + 1'b1;
      for (int l = 0; l < NumChan; l++) begin
        if (accr_wrap[l]) begin
          accr_q[l] <= ChanW'(accr_sum[l] - {1'b0, len_q});
          acc_q[l]  <= acc_q[l] + quo_q[l] + 1'b1;
        end else begin
          accr_q[l] <= accr_sum[l][ChanW-1:0];
          acc_q[l]  <= acc_q[l] + quo_q[l];
        end
      end
    end
    if (ram_re) begin
      rd_valid_q <= valid_q[in_index];
      tv_hold_q  <= (seen_q == 2'd2);
    end
    if (out_load) begin
      out_entry_q <= rd_valid_q ? rgba_t'(ram_rdata) : '0;
      out_tv_q    <= tv_hold_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'({out_tv_q, EntryW'(out_entry_q)});

  // The walk never runs past the segment end.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FILL) |-> (k_q <= len_q))
    else $error("segment walk ran past its end");

  // The running remainder of the first channel stays below the segment length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_FILL) && (len_q != '0)) |-> (accr_q[0] < len_q))
    else $error("interpolation remainder out of range");

  // The interpolated step of the first channel never exceeds its colour difference.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FILL) |-> (acc_q[0] <= mag_q[0]))
    else $error("interpolation overshoots the segment colour");

  // A node that extends the ramp starts a divide or a walk.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_mode == MODE_NODE) && seg_go) |=>
      ((state_q == S_DIV) || (state_q == S_FILL)))
    else $error("segment request lost");

endmodule
